### hdl/pbts_pkg.sv
`timescale 1ns / 1ps
package pbts_pkg;

  localparam int NUM_THREADS_DEF = 16;
  localparam int PRIO_LEVELS_DEF = 16;
  localparam int FLAG_BITS_DEF   = 16;

  typedef enum logic [3:0] {
    K_CREATE    = 4'd0,
    K_WAKE      = 4'd1,
    K_SLEEP     = 4'd2,
    K_YIELD     = 4'd3,
    K_EXIT      = 4'd4,
    K_SCHEDULE  = 4'd5,
    K_SETFLAGS  = 4'd6,
    K_CLRFLAGS  = 4'd7,
    K_WAITANY   = 4'd8,
    K_WAITALL   = 4'd9,
    K_WAITONE   = 4'd10
  } kind_t;

  typedef enum logic [2:0] {
    C_OK           = 3'd0,
    C_NO_SLOT      = 3'd1,
    C_BAD_PRIO     = 3'd2,
    C_NOT_FOUND    = 3'd3,
    C_NOT_SLEEPING = 3'd4,
    C_BLOCKED      = 3'd5,
    C_NONE_READY   = 3'd6,
    C_IGNORED      = 3'd7
  } code_t;

  typedef enum logic [2:0] {
    ST_STOPPED   = 3'd0,
    ST_SLEEPING  = 3'd1,
    ST_BLOCK_ANY = 3'd2,
    ST_BLOCK_ALL = 3'd3,
    ST_RUNNING   = 3'd4,
    ST_PENDING   = 3'd5
  } status_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  target_thread;
    logic [3:0]  priority_req;
    logic [15:0] flag_mask;
    logic [1:0]  create_options;
    logic        in_isr;
  } req_t;

  typedef struct packed {
    logic [3:0]  thread_id;
    logic [2:0]  code;
    logic [15:0] flags_value;
    logic        switch_now;
    logic        switch_deferred;
  } rsp_t;

endpackage

### hdl/pbts_ffs.sv
`timescale 1ns / 1ps
module pbts_ffs #(
  parameter int W = 16
) (
  input  logic [W-1:0]         bits,
  output logic                 found,
  output logic [$clog2(W)-1:0] idx
);
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (bits[i]) begin
        found = 1'b1;
        idx   = $clog2(W)'(i);
      end
    end
  end
endmodule

### hdl/pbts_engine.sv
`timescale 1ns / 1ps
module pbts_engine #(
  parameter int NUM_THREADS = pbts_pkg::NUM_THREADS_DEF,
  parameter int PRIO_LEVELS = pbts_pkg::PRIO_LEVELS_DEF,
  parameter int FLAG_BITS   = pbts_pkg::FLAG_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           req_vld,
  input  pbts_pkg::req_t req,
  output logic           take,
  output logic           out_valid,
  input  logic           out_ready,
  output pbts_pkg::rsp_t out_data
);
  import pbts_pkg::*;

  localparam int IDX_W  = $clog2(NUM_THREADS);
  localparam int TID_W  = $clog2(NUM_THREADS + 1);
  localparam int PIDX_W = $clog2(PRIO_LEVELS);
  localparam int CNT_W  = $clog2(NUM_THREADS + 1);

  logic [NUM_THREADS-1:0] slot_used_r, slot_used_nxt;
  status_t                status_r  [NUM_THREADS];
  status_t                status_nxt[NUM_THREADS];
  logic [PIDX_W-1:0]      prio_r    [NUM_THREADS];
  logic [PIDX_W-1:0]      prio_nxt  [NUM_THREADS];
  logic [FLAG_BITS-1:0]   flags_r   [NUM_THREADS];
  logic [FLAG_BITS-1:0]   flags_nxt [NUM_THREADS];
  logic [FLAG_BITS-1:0]   wmask_r   [NUM_THREADS];
  logic [FLAG_BITS-1:0]   wmask_nxt [NUM_THREADS];
  logic [IDX_W-1:0]       rank_r    [NUM_THREADS];
  logic [IDX_W-1:0]       rank_nxt  [NUM_THREADS];
  logic [CNT_W-1:0]       count_r   [PRIO_LEVELS];
  logic [CNT_W-1:0]       count_nxt [PRIO_LEVELS];
  logic [TID_W-1:0]       cur_r, cur_nxt;
  logic                   defer_r, defer_nxt;
  logic                   out_valid_r;
  rsp_t                   out_r, out_nxt;

  logic [NUM_THREADS-1:0] inq, running;
  logic [PRIO_LEVELS-1:0] ready_bm;
  logic                   free_found, rdy_found;
  logic [IDX_W-1:0]       free_idx;
  logic [PIDX_W-1:0]      sp;
  logic                   hd_found;
  logic [IDX_W-1:0]       hd;

  always_comb begin
    for (int t = 0; t < NUM_THREADS; t++) begin
      inq[t]     = (status_r[t] == ST_RUNNING) || (status_r[t] == ST_PENDING);
      running[t] = (status_r[t] == ST_RUNNING);
    end
    for (int p = 0; p < PRIO_LEVELS; p++) begin
      ready_bm[p] = (count_r[p] != '0);
    end
  end

  pbts_ffs #(.W(NUM_THREADS)) u_free (
    .bits  (~slot_used_r),
    .found (free_found),
    .idx   (free_idx)
  );

  pbts_ffs #(.W(PRIO_LEVELS)) u_ready (
    .bits  (ready_bm),
    .found (rdy_found),
    .idx   (sp)
  );

  always_comb begin
    hd_found = 1'b0;
    hd       = '0;
    for (int t = 0; t < NUM_THREADS; t++) begin
      if (inq[t] && prio_r[t] == sp && rank_r[t] == '0) begin
        hd_found = 1'b1;
        hd       = IDX_W'(t);
      end
    end
  end

  assign take = req_vld && (!out_valid_r || out_ready);

  always_comb begin
    logic [IDX_W-1:0]     c, ti, st_t;
    logic                 c_ok, t_ok, now, wake, blk, need, st_en, q_rot;
    logic [PIDX_W-1:0]    st_p, qp, np;
    logic [FLAG_BITS-1:0] mask, have, fl, fval;
    logic [IDX_W-1:0]     r0;
    logic [TID_W-1:0]     tid;
    code_t                code;
    status_t              old_s, new_s;
    kind_t                kind;

    slot_used_nxt = slot_used_r;
    status_nxt    = status_r;
    prio_nxt      = prio_r;
    flags_nxt     = flags_r;
    wmask_nxt     = wmask_r;
    rank_nxt      = rank_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    defer_nxt     = defer_r;

    kind  = kind_t'(req.kind);
    c     = cur_r[IDX_W-1:0];
    c_ok  = cur_r < TID_W'(NUM_THREADS);
    ti    = IDX_W'(req.target_thread);
    t_ok  = (int'(req.target_thread) < NUM_THREADS) && slot_used_r[ti];
    mask  = FLAG_BITS'(req.flag_mask);
    np    = PIDX_W'(req.priority_req);
    now   = 1'b0;
    wake  = 1'b0;
    blk   = 1'b0;
    need  = 1'b0;
    st_en = 1'b0;
    st_t  = '0;
    st_p  = '0;
    new_s = ST_STOPPED;
    q_rot = 1'b0;
    qp    = '0;
    have  = '0;
    fl    = '0;
    fval  = '0;
    tid   = '0;
    code  = C_OK;
    r0    = '0;
    old_s = ST_STOPPED;

    if (req.kind >= 4'(K_SLEEP) && req.kind <= 4'(K_WAITONE) && kind != K_SCHEDULE &&
        kind != K_SETFLAGS && !c_ok && !(kind == K_SLEEP && req.in_isr)) begin
      code = C_NOT_FOUND;
    end else begin
      case (kind)
        K_CREATE: begin
          if (int'(req.priority_req) >= PRIO_LEVELS) begin
            code = C_BAD_PRIO;
          end else if (!free_found) begin
            code = C_NO_SLOT;
          end else begin
            slot_used_nxt[free_idx] = 1'b1;
            prio_nxt[free_idx]      = np;
            flags_nxt[free_idx]     = '0;
            wmask_nxt[free_idx]     = '0;
            tid   = TID_W'(free_idx);
            st_en = 1'b1;
            st_t  = free_idx;
            st_p  = np;
            new_s = req.create_options[0] ? ST_SLEEPING : ST_PENDING;
            need  = !req.create_options[0] && !req.create_options[1] &&
                    (!c_ok || !inq[c] || prio_r[c] > np);
          end
        end
        K_WAKE: begin
          if (!t_ok) begin
            code = C_NOT_FOUND;
          end else if (status_r[ti] != ST_SLEEPING) begin
            code = C_NOT_SLEEPING;
          end else begin
            st_en = 1'b1;
            st_t  = ti;
            st_p  = prio_r[ti];
            new_s = ST_PENDING;
            need  = !c_ok || (!inq[c] && c != ti) || prio_r[c] > prio_r[ti];
          end
        end
        K_SLEEP: begin
          if (req.in_isr) begin
            code = C_IGNORED;
          end else begin
            st_en = 1'b1;
            st_t  = c;
            st_p  = prio_r[c];
            new_s = ST_SLEEPING;
            now   = 1'b1;
          end
        end
        K_YIELD: begin
          q_rot = inq[c];
          qp    = prio_r[c];
          now   = 1'b1;
        end
        K_EXIT: begin
          slot_used_nxt[c] = 1'b0;
          st_en   = 1'b1;
          st_t    = c;
          st_p    = prio_r[c];
          new_s   = ST_STOPPED;
          cur_nxt = TID_W'(NUM_THREADS);
          now     = 1'b1;
        end
        K_SCHEDULE: begin
          defer_nxt = 1'b0;
          if (!rdy_found || !hd_found) begin
            code = C_NONE_READY;
          end else begin
            tid = TID_W'(hd);
            if (cur_r != TID_W'(hd)) begin
              if (c_ok && status_r[c] == ST_RUNNING) begin
                status_nxt[c] = ST_PENDING;
              end
              status_nxt[hd] = ST_RUNNING;
              cur_nxt        = TID_W'(hd);
            end
          end
        end
        K_SETFLAGS: begin
          if (!t_ok) begin
            code = C_NOT_FOUND;
          end else begin
            fl            = flags_r[ti] | mask;
            flags_nxt[ti] = fl;
            wake = (status_r[ti] == ST_BLOCK_ANY && (fl & wmask_r[ti]) != '0) ||
                   (status_r[ti] == ST_BLOCK_ALL && (fl & wmask_r[ti]) == wmask_r[ti]);
            if (wake) begin
              st_en = 1'b1;
              st_t  = ti;
              st_p  = prio_r[ti];
              new_s = ST_PENDING;
              need  = 1'b1;
            end
          end
        end
        K_CLRFLAGS: begin
          have         = mask & flags_r[c];
          flags_nxt[c] = flags_r[c] & ~have;
          fval         = have;
        end
        K_WAITANY, K_WAITALL, K_WAITONE: begin
          have = flags_r[c] & mask;
          blk  = (kind == K_WAITALL) ? (have != mask) : (have == '0);
          if (blk) begin
            wmask_nxt[c] = mask;
            st_en = 1'b1;
            st_t  = c;
            st_p  = prio_r[c];
            new_s = (kind == K_WAITALL) ? ST_BLOCK_ALL : ST_BLOCK_ANY;
            now   = 1'b1;
            code  = C_BLOCKED;
          end else begin
            if (kind == K_WAITONE) begin
              have = have & (~have + 1'b1);
            end
            flags_nxt[c] = flags_r[c] & ~have;
            fval         = have;
          end
        end
        default: begin
          code = C_IGNORED;
        end
      endcase
    end

    if (need) begin
      if (req.in_isr) begin
        defer_nxt = 1'b1;
      end else begin
        now = 1'b1;
      end
    end

    if (st_en) begin
      old_s            = status_r[st_t];
      status_nxt[st_t] = new_s;
      if ((new_s == ST_RUNNING || new_s == ST_PENDING) &&
          !(old_s == ST_RUNNING || old_s == ST_PENDING)) begin
        rank_nxt[st_t]  = IDX_W'(count_r[st_p]);
        count_nxt[st_p] = count_r[st_p] + 1'b1;
      end else if (!(new_s == ST_RUNNING || new_s == ST_PENDING) &&
                   (old_s == ST_RUNNING || old_s == ST_PENDING)) begin
        r0 = rank_r[st_t];
        for (int t = 0; t < NUM_THREADS; t++) begin
          if (inq[t] && prio_r[t] == st_p && rank_r[t] > r0) begin
            rank_nxt[t] = rank_r[t] - 1'b1;
          end
        end
        count_nxt[st_p] = count_r[st_p] - 1'b1;
      end
    end

    if (q_rot && count_r[qp] != '0) begin
      for (int t = 0; t < NUM_THREADS; t++) begin
        if (inq[t] && prio_r[t] == qp) begin
          rank_nxt[t] = (rank_r[t] == '0) ? IDX_W'(count_r[qp] - 1'b1) : rank_r[t] - 1'b1;
        end
      end
    end

    out_nxt.thread_id       = 4'(tid);
    out_nxt.code            = code;
    out_nxt.flags_value     = 16'(fval);
    out_nxt.switch_now      = now;
    out_nxt.switch_deferred = defer_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_used_r <= '0;
      for (int t = 0; t < NUM_THREADS; t++) begin
        status_r[t] <= ST_STOPPED;
        prio_r[t]   <= PIDX_W'(PRIO_LEVELS - 1);
        flags_r[t]  <= '0;
        wmask_r[t]  <= '0;
        rank_r[t]   <= '0;
      end
      for (int p = 0; p < PRIO_LEVELS; p++) begin
        count_r[p] <= '0;
      end
      cur_r       <= TID_W'(NUM_THREADS);
      defer_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        slot_used_r <= slot_used_nxt;
        status_r    <= status_nxt;
        prio_r      <= prio_nxt;
        flags_r     <= flags_nxt;
        wmask_r     <= wmask_nxt;
        rank_r      <= rank_nxt;
        count_r     <= count_nxt;
        cur_r       <= cur_nxt;
        defer_r     <= defer_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_ready_matches_queues: assert property (@(posedge clk) disable iff (!rst_n)
    (|ready_bm) == (|inq))
    else $error("ready bitmap disagrees with queued threads");

  a_current_slot_used: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_r < TID_W'(NUM_THREADS)) |-> slot_used_r[cur_r[IDX_W-1:0]])
    else $error("current thread occupies a free slot");

  a_single_running: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(running))
    else $error("more than one thread running");

  a_defer_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    take && kind_t'(req.kind) == K_SCHEDULE |=> !defer_r)
    else $error("schedule left a deferred switch pending");

endmodule

### hdl/priority_bitmap_thread_scheduler_core.sv
`timescale 1ns / 1ps
// Priority bitmap thread scheduler. Each request (create, wake, sleep, yield, exit, schedule,
// set/clear flags, wait any/all/one) yields exactly one response carrying the chosen thread,
// a status code, returned flags and switch indications. Requests pass through an input
// register and are resolved combinationally by priority encoders over the thread table and
// per-priority queue ranks into an output register; one transaction per cycle is sustained
// while the response side keeps up.
module priority_bitmap_thread_scheduler_core #(
  parameter int NUM_THREADS = pbts_pkg::NUM_THREADS_DEF,
  parameter int PRIO_LEVELS = pbts_pkg::PRIO_LEVELS_DEF,
  parameter int FLAG_BITS   = pbts_pkg::FLAG_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pbts_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pbts_pkg::rsp_t out_data
);
  import pbts_pkg::*;

  logic in_vld_r;
  req_t in_r;
  logic take;

  assign in_ready = !in_vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  pbts_engine #(
    .NUM_THREADS (NUM_THREADS),
    .PRIO_LEVELS (PRIO_LEVELS),
    .FLAG_BITS   (FLAG_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_vld   (in_vld_r),
    .req       (in_r),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
